>>> design/btcsi_pkg.sv
// shared types, codes and helpers for the b-tree interior node unit
`timescale 1ns / 1ps

package btcsi_pkg;

    typedef enum logic [2:0] {
        FUNC_LOOKUP    = 3'd0,
        FUNC_INS_CHILD = 3'd1,
        FUNC_APPEND    = 3'd2,
        FUNC_SORTED    = 3'd3,
        FUNC_READ_KEY  = 3'd4
    } t_func;

    typedef struct packed {
        logic [2:0]         func;
        logic signed [63:0] search_key;
        logic [31:0]        child_page;
        logic [5:0]         cell_index;
    } t_req;

    typedef struct packed {
        logic [31:0]        target_page;
        logic               page_valid;
        logic signed [63:0] key_out;
        logic               ok;
    } t_rsp;

    typedef struct packed {
        logic wr_key;
        logic wr_page;
    } t_mem_we;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LAST,
        S_SCAN,
        S_SHIFT,
        S_PUT,
        S_RDKEY,
        S_DONE
    } t_state;

    // result that selects the right-most child, or nothing when it is unset
    function automatic t_rsp rsp_right(input logic [31:0] right, input logic right_set);
        t_rsp rsp;
        rsp             = '0;
        rsp.target_page = right_set ? right : 32'd0;
        rsp.page_valid  = right_set;
        rsp.ok          = 1'b1;
        return rsp;
    endfunction

endpackage

>>> design/btcsi_cell_mem.sv
// cell storage: separator keys and child pages, one write and one registered read per cycle
`timescale 1ns / 1ps

module btcsi_cell_mem #(
    parameter int DEPTH = 64
) (
    input  logic                       i_clk,
    input  btcsi_pkg::t_mem_we         i_we,
    input  logic [$clog2(DEPTH)-1:0]   i_waddr,
    input  logic [63:0]                i_wkey,
    input  logic [31:0]                i_wpage,
    input  logic [$clog2(DEPTH)-1:0]   i_raddr,
    output logic [63:0]                o_rd_key,
    output logic [31:0]                o_rd_page
);

    logic [63:0] r_key_mem  [DEPTH];
    logic [31:0] r_page_mem [DEPTH];
    logic [63:0] r_rd_key;
    logic [31:0] r_rd_page;

    always_ff @(posedge i_clk) begin
        if (i_we.wr_key) begin
            r_key_mem[i_waddr] <= i_wkey;
        end
        if (i_we.wr_page) begin
            r_page_mem[i_waddr] <= i_wpage;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_key  <= r_key_mem[i_raddr];
        r_rd_page <= r_page_mem[i_raddr];
    end

    assign o_rd_key  = r_rd_key;
    assign o_rd_page = r_rd_page;

endmodule

>>> design/btcsi_seq.sv
// request sequencer: node registers, cell scan, shift for sorted insert
`timescale 1ns / 1ps

module btcsi_seq #(
    parameter int NODE_CELLS = 64
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  btcsi_pkg::t_req                 i_in_req,
    input  logic                            i_out_free,
    output logic                            o_done,
    output btcsi_pkg::t_rsp                 o_rsp,
    output btcsi_pkg::t_mem_we              o_mem_we,
    output logic [$clog2(NODE_CELLS)-1:0]   o_waddr,
    output logic [63:0]                     o_wkey,
    output logic [31:0]                     o_wpage,
    output logic [$clog2(NODE_CELLS)-1:0]   o_raddr,
    input  logic [63:0]                     i_rd_key,
    input  logic [31:0]                     i_rd_page
);

    localparam int AW = $clog2(NODE_CELLS);
    localparam int CW = $clog2(NODE_CELLS + 1);

    btcsi_pkg::t_state r_state, n_state;
    btcsi_pkg::t_req   r_req, n_req;
    btcsi_pkg::t_rsp   r_rsp, n_rsp;
    logic [CW-1:0]     r_count, n_count;
    logic [31:0]       r_right, n_right;
    logic              r_right_set, n_right_set;
    logic [AW-1:0]     r_idx, n_idx;
    logic [AW-1:0]     r_pos, n_pos;
    logic [31:0]       r_prev_page, n_prev_page;

    logic signed [63:0] w_key;
    logic signed [63:0] w_sep;
    logic [CW-1:0]      w_idx_inc;
    logic               w_last;
    logic               w_full;
    logic [31:0]        w_cidx;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= btcsi_pkg::S_IDLE;
            r_count     <= '0;
            r_right     <= '0;
            r_right_set <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_right     <= n_right;
            r_right_set <= n_right_set;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req       <= n_req;
        r_rsp       <= n_rsp;
        r_idx       <= n_idx;
        r_pos       <= n_pos;
        r_prev_page <= n_prev_page;
    end

    assign w_key     = r_req.search_key;
    assign w_sep     = $signed(i_rd_key);
    assign w_idx_inc = CW'(r_idx) + CW'(1);
    assign w_last    = (w_idx_inc == r_count);
    assign w_full    = (r_count == CW'(NODE_CELLS));
    assign w_cidx    = 32'(i_in_req.cell_index);

    always_comb begin
        n_state     = r_state;
        n_req       = r_req;
        n_rsp       = r_rsp;
        n_count     = r_count;
        n_right     = r_right;
        n_right_set = r_right_set;
        n_idx       = r_idx;
        n_pos       = r_pos;
        n_prev_page = r_prev_page;
        o_mem_we    = '0;
        o_waddr     = r_count[AW-1:0];
        o_wkey      = r_req.search_key;
        o_wpage     = r_right;
        o_raddr     = w_idx_inc[AW-1:0];
        o_done      = 1'b0;

        case (r_state)
            btcsi_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_req       = i_in_req;
                    n_rsp       = '0;
                    n_rsp.ok    = 1'b1;
                    n_idx       = '0;
                    n_prev_page = '0;
                    o_raddr     = '0;
                    n_state     = btcsi_pkg::S_DONE;
                    case (i_in_req.func)
                        btcsi_pkg::FUNC_LOOKUP: begin
                            if (r_count == '0) begin
                                n_rsp = btcsi_pkg::rsp_right(r_right, r_right_set);
                            end else begin
                                n_state = btcsi_pkg::S_SCAN;
                            end
                        end
                        btcsi_pkg::FUNC_INS_CHILD: begin
                            if (r_count == '0) begin
                                n_rsp = btcsi_pkg::rsp_right(r_right, r_right_set);
                            end else begin
                                o_raddr = AW'(r_count - CW'(1));
                                n_state = btcsi_pkg::S_LAST;
                            end
                        end
                        btcsi_pkg::FUNC_APPEND, btcsi_pkg::FUNC_SORTED: begin
                            if (w_full) begin
                                n_rsp.ok = 1'b0;
                            end else if (!r_right_set) begin
                                n_right     = i_in_req.child_page;
                                n_right_set = 1'b1;
                            end else if (i_in_req.func == btcsi_pkg::FUNC_APPEND ||
                                         r_count == '0) begin
                                // old right child moves into a new last cell
                                o_mem_we = '{wr_key: 1'b1, wr_page: 1'b1};
                                o_wkey   = i_in_req.search_key;
                                o_wpage  = r_right;
                                n_right  = i_in_req.child_page;
                                n_count  = r_count + CW'(1);
                            end else begin
                                n_state = btcsi_pkg::S_SCAN;
                            end
                        end
                        btcsi_pkg::FUNC_READ_KEY: begin
                            if (w_cidx >= 32'(NODE_CELLS)) begin
                                n_rsp.ok = 1'b0;
                            end else if (w_cidx < 32'(r_count)) begin
                                o_raddr = w_cidx[AW-1:0];
                                n_state = btcsi_pkg::S_RDKEY;
                            end
                            // cells at or above the count are not read: key reads zero
                        end
                        default: begin
                            n_rsp.ok = 1'b0;
                        end
                    endcase
                end
            end

            btcsi_pkg::S_LAST: begin
                // key not below the last separator goes to the right child
                if (!(w_key < w_sep)) begin
                    n_rsp   = btcsi_pkg::rsp_right(r_right, r_right_set);
                    n_state = btcsi_pkg::S_DONE;
                end else begin
                    o_raddr = '0;
                    n_idx   = '0;
                    n_state = btcsi_pkg::S_SCAN;
                end
            end

            btcsi_pkg::S_SCAN: begin
                // read data belongs to cell r_idx, next cell read is already issued
                case (r_req.func)
                    btcsi_pkg::FUNC_LOOKUP: begin
                        if (!(w_sep < w_key)) begin
                            n_rsp.page_valid = 1'b1;
                            if (i_rd_key == r_req.search_key && r_idx != '0) begin
                                n_rsp.target_page = r_prev_page;
                            end else begin
                                n_rsp.target_page = i_rd_page;
                            end
                            n_state = btcsi_pkg::S_DONE;
                        end else if (w_last) begin
                            n_rsp   = btcsi_pkg::rsp_right(r_right, r_right_set);
                            n_state = btcsi_pkg::S_DONE;
                        end else begin
                            n_idx       = w_idx_inc[AW-1:0];
                            n_prev_page = i_rd_page;
                        end
                    end
                    btcsi_pkg::FUNC_INS_CHILD: begin
                        if (w_key < w_sep) begin
                            n_rsp.page_valid  = 1'b1;
                            n_rsp.target_page = i_rd_page;
                            n_state           = btcsi_pkg::S_DONE;
                        end else if (w_last) begin
                            n_rsp   = btcsi_pkg::rsp_right(r_right, r_right_set);
                            n_state = btcsi_pkg::S_DONE;
                        end else begin
                            n_idx = w_idx_inc[AW-1:0];
                        end
                    end
                    default: begin
                        if (w_key < w_sep) begin
                            n_pos   = r_idx;
                            n_idx   = AW'(r_count - CW'(1));
                            o_raddr = AW'(r_count - CW'(1));
                            n_state = btcsi_pkg::S_SHIFT;
                        end else if (w_last) begin
                            o_mem_we = '{wr_key: 1'b1, wr_page: 1'b1};
                            o_wpage  = r_right;
                            n_right  = r_req.child_page;
                            n_count  = r_count + CW'(1);
                            n_state  = btcsi_pkg::S_DONE;
                        end else begin
                            n_idx = w_idx_inc[AW-1:0];
                        end
                    end
                endcase
            end

            btcsi_pkg::S_SHIFT: begin
                // move cell r_idx up by one, top down; the new page lands above the slot
                o_mem_we = '{wr_key: 1'b1, wr_page: 1'b1};
                o_waddr  = w_idx_inc[AW-1:0];
                o_wkey   = i_rd_key;
                if (r_idx == r_pos) begin
                    o_wpage = r_req.child_page;
                    n_state = btcsi_pkg::S_PUT;
                end else begin
                    o_wpage = i_rd_page;
                    o_raddr = r_idx - AW'(1);
                    n_idx   = r_idx - AW'(1);
                end
            end

            btcsi_pkg::S_PUT: begin
                o_mem_we = '{wr_key: 1'b1, wr_page: 1'b0};
                o_waddr  = r_pos;
                o_wkey   = r_req.search_key;
                n_count  = r_count + CW'(1);
                n_state  = btcsi_pkg::S_DONE;
            end

            btcsi_pkg::S_RDKEY: begin
                n_rsp.key_out = $signed(i_rd_key);
                n_state       = btcsi_pkg::S_DONE;
            end

            btcsi_pkg::S_DONE: begin
                o_done = 1'b1;
                if (i_out_free) begin
                    n_state = btcsi_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = btcsi_pkg::S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != btcsi_pkg::S_IDLE);
    assign o_rsp      = r_rsp;

endmodule

>>> design/btree_node_child_select_insert_unit.sv
// top level of the b-tree interior node unit: sequencer, cell memory, result register
`timescale 1ns / 1ps

// Holds one interior node of a B+ tree and serves one request at a time.
// Input channel: i_in_valid / o_in_stall with payload i_in_req (func, search_key,
// child_page, cell_index). A request is taken when valid is high and stall is low;
// stall is high while a request is being worked on.
// Output channel: o_out_valid / i_out_stall with payload o_out_rsp. Exactly one
// result per request, in order, held in an output register.
// Lookup and insert child search the cells; sorted insert searches and then shifts
// them; append, full node, read key and unknown func need no search.
// Cell searches are linear scans, one cell per cycle through the single read port
// of the cell memory; the sorted insert then moves one cell per cycle through it.
// A new request is accepted while the previous result still sits in the output
// register; the block holds a finished result until the register is free, so a
// stalled receiver stalls the block after at most one further request.
// Reset (synchronous, active low) empties the node and unsets the right child at
// once: cells at or above the count read as zero, so no clearing pass is needed.
module btree_node_child_select_insert_unit #(
    parameter int NODE_CELLS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  btcsi_pkg::t_req   i_in_req,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output btcsi_pkg::t_rsp   o_out_rsp
);

    localparam int AW = $clog2(NODE_CELLS);

    btcsi_pkg::t_mem_we w_mem_we;
    logic [AW-1:0]      w_waddr;
    logic [63:0]        w_wkey;
    logic [31:0]        w_wpage;
    logic [AW-1:0]      w_raddr;
    logic [63:0]        w_rd_key;
    logic [31:0]        w_rd_page;
    logic               w_done;
    btcsi_pkg::t_rsp    w_rsp;
    logic               w_out_free;

    logic               r_out_valid;
    btcsi_pkg::t_rsp    r_out_rsp;

    assign w_out_free = !r_out_valid || !i_out_stall;

    btcsi_seq #(
        .NODE_CELLS (NODE_CELLS)
    ) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_req   (i_in_req),
        .i_out_free (w_out_free),
        .o_done     (w_done),
        .o_rsp      (w_rsp),
        .o_mem_we   (w_mem_we),
        .o_waddr    (w_waddr),
        .o_wkey     (w_wkey),
        .o_wpage    (w_wpage),
        .o_raddr    (w_raddr),
        .i_rd_key   (w_rd_key),
        .i_rd_page  (w_rd_page)
    );

    btcsi_cell_mem #(
        .DEPTH (NODE_CELLS)
    ) u_mem (
        .i_clk     (i_clk),
        .i_we      (w_mem_we),
        .i_waddr   (w_waddr),
        .i_wkey    (w_wkey),
        .i_wpage   (w_wpage),
        .i_raddr   (w_raddr),
        .o_rd_key  (w_rd_key),
        .o_rd_page (w_rd_page)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_free) begin
            r_out_valid <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_free && w_done) begin
            r_out_rsp <= w_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

>>> design/btcsi_checker.sv
// port-level assertions for the b-tree interior node unit, bound to the top level
`timescale 1ns / 1ps

module btcsi_checker (
    input logic            i_clk,
    input logic            i_rst_n,
    input logic            i_in_valid,
    input logic            o_in_stall,
    input btcsi_pkg::t_req i_in_req,
    input logic            o_out_valid,
    input logic            i_out_stall,
    input btcsi_pkg::t_rsp o_out_rsp
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_rsp))
        else $error("stalled result changed or dropped");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    // one request at a time: busy the cycle after a request is taken
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("request taken while previous one still in work");

    a_refused_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_rsp.ok |-> !o_out_rsp.page_valid &&
        o_out_rsp.target_page == 32'd0)
        else $error("refused request carries a page");

    a_page_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_rsp.page_valid |-> o_out_rsp.target_page == 32'd0)
        else $error("undefined page not zero");

endmodule

bind btree_node_child_select_insert_unit btcsi_checker u_chk (.*);
